@@ rtl/tksd_pkg.sv @@
// Package of types and constants shared by the terminal key sequence decoder.
package tksd_pkg;

    // Decoder mode: plain bytes, after ESC, inside a CSI sequence.
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_CSI    = 2'd2
    } mode_t;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        mode_t       mode;
        logic [7:0]  first_param;
        logic [3:0]  param_cnt;
        logic [20:0] accum;
        logic [1:0]  cont_left;
    } tksd_state_t;

    // Received byte values of interest.
    localparam logic [7:0] KEY_ESC     = 8'h1B;
    localparam logic [7:0] KEY_DEL     = 8'h7F;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UP       = 8'h41;
    localparam logic [7:0] CH_DOWN     = 8'h42;
    localparam logic [7:0] CH_RIGHT    = 8'h43;
    localparam logic [7:0] CH_LEFT     = 8'h44;

    // Key codes produced for editing keys.
    localparam logic [20:0] KC_HOME  = 21'h01;
    localparam logic [20:0] KC_LEFT  = 21'h02;
    localparam logic [20:0] KC_END   = 21'h05;
    localparam logic [20:0] KC_RIGHT = 21'h06;
    localparam logic [20:0] KC_BKSP  = 21'h08;
    localparam logic [20:0] KC_DOWN  = 21'h0E;
    localparam logic [20:0] KC_UP    = 21'h10;

    // Largest Unicode code point.
    localparam logic [20:0] CODE_MAX = 21'h10FFFF;

    // Saturation limits of the CSI parameter collection.
    localparam logic [7:0] PARAM_MAX = 8'hFF;
    localparam logic [3:0] COUNT_MAX = 4'hF;

endpackage

@@ rtl/tksd_step.sv @@
// Combinational next-state and key code logic for one received byte.
module tksd_step (
    input  logic [7:0]          rx_byte,
    input  tksd_pkg::tksd_state_t state_cur,
    output tksd_pkg::tksd_state_t state_nxt,
    output logic                emit,
    output logic [20:0]         key_code
);
    import tksd_pkg::*;

    logic        is_digit;
    logic        is_cont;
    logic        form_bad;
    logic [11:0] param_sum;
    logic [7:0]  param_sat;
    logic [3:0]  count_inc;
    logic [20:0] accum_shift;
    logic [1:0]  cont_dec;
    mode_t       mode_nxt;

    // Byte classes and the arithmetic used by several branches.
    always_comb begin
        is_digit    = (rx_byte inside {[CH_ZERO:CH_NINE]});
        is_cont     = (rx_byte[7:6] == 2'b10);
        param_sum   = {4'd0, state_cur.first_param} * 12'd10 + {8'd0, rx_byte[3:0]};
        param_sat   = (param_sum > 12'd255) ? PARAM_MAX : param_sum[7:0];
        count_inc   = (state_cur.param_cnt == COUNT_MAX) ? COUNT_MAX
                                                          : state_cur.param_cnt + 4'd1;
        accum_shift = {state_cur.accum[14:0], rx_byte[5:0]};
        cont_dec    = state_cur.cont_left - 2'd1;
        // Overlong, surrogate and out-of-range forms show on the second byte.
        form_bad    = 1'b0;
        if (state_cur.cont_left == 2'd3) begin
            form_bad = (state_cur.accum == 21'd0 && rx_byte < 8'h90) ||
                       (state_cur.accum == 21'd4 && rx_byte > 8'h8F);
        end else if (state_cur.cont_left == 2'd2 && state_cur.accum < 21'h10) begin
            form_bad = (state_cur.accum == 21'd0 && rx_byte < 8'hA0) ||
                       (state_cur.accum == 21'hD && rx_byte > 8'h9F);
        end
    end

    // Next mode.
    always_comb begin
        mode_nxt = state_cur.mode;
        case (state_cur.mode)
            MODE_NORMAL: begin
                if (rx_byte == KEY_ESC) begin
                    mode_nxt = MODE_ESC;
                end
            end
            MODE_ESC: begin
                mode_nxt = (rx_byte == CH_LBRACKET) ? MODE_CSI : MODE_NORMAL;
            end
            MODE_CSI: begin
                if (!is_digit && rx_byte != CH_SEMI) begin
                    mode_nxt = MODE_NORMAL;
                end
            end
            default: begin
                mode_nxt = MODE_NORMAL;
            end
        endcase
    end

    // Data state and key code.
    always_comb begin
        state_nxt.mode        = mode_nxt;
        state_nxt.first_param = state_cur.first_param;
        state_nxt.param_cnt   = state_cur.param_cnt;
        state_nxt.accum       = state_cur.accum;
        state_nxt.cont_left   = state_cur.cont_left;
        emit                  = 1'b0;
        key_code              = 21'd0;
        case (state_cur.mode)
            MODE_NORMAL: begin
                if (rx_byte == KEY_ESC) begin
                    state_nxt.accum     = 21'd0;
                    state_nxt.cont_left = 2'd0;
                end else if (rx_byte == KEY_DEL) begin
                    state_nxt.accum     = 21'd0;
                    state_nxt.cont_left = 2'd0;
                    emit                = 1'b1;
                    key_code            = KC_BKSP;
                end else if (state_cur.cont_left != 2'd0 && is_cont) begin
                    // Continuation byte of a code point under way.
                    if (form_bad) begin
                        state_nxt.accum     = 21'd0;
                        state_nxt.cont_left = 2'd0;
                    end else if (cont_dec == 2'd0) begin
                        state_nxt.accum     = 21'd0;
                        state_nxt.cont_left = 2'd0;
                        emit                = 1'b1;
                        key_code            = accum_shift;
                    end else begin
                        state_nxt.accum     = accum_shift;
                        state_nxt.cont_left = cont_dec;
                    end
                end else begin
                    // Start of a new code point; any partial one is dropped.
                    state_nxt.accum     = 21'd0;
                    state_nxt.cont_left = 2'd0;
                    if (!rx_byte[7]) begin
                        emit     = 1'b1;
                        key_code = {13'd0, rx_byte};
                    end else if (rx_byte inside {[8'hC2:8'hDF]}) begin
                        state_nxt.accum     = {16'd0, rx_byte[4:0]};
                        state_nxt.cont_left = 2'd1;
                    end else if (rx_byte inside {[8'hE0:8'hEF]}) begin
                        state_nxt.accum     = {17'd0, rx_byte[3:0]};
                        state_nxt.cont_left = 2'd2;
                    end else if (rx_byte inside {[8'hF0:8'hF4]}) begin
                        state_nxt.accum     = {18'd0, rx_byte[2:0]};
                        state_nxt.cont_left = 2'd3;
                    end
                end
            end
            MODE_ESC: begin
                if (rx_byte == CH_LBRACKET) begin
                    state_nxt.first_param = 8'd0;
                    state_nxt.param_cnt   = 4'd0;
                end
            end
            MODE_CSI: begin
                if (is_digit) begin
                    // Only the first parameter's digits are kept.
                    if (state_cur.param_cnt == 4'd0) begin
                        state_nxt.first_param = param_sat;
                    end
                end else begin
                    state_nxt.param_cnt = count_inc;
                    case (rx_byte)
                        CH_UP: begin
                            emit     = 1'b1;
                            key_code = KC_UP;
                        end
                        CH_DOWN: begin
                            emit     = 1'b1;
                            key_code = KC_DOWN;
                        end
                        CH_RIGHT: begin
                            emit     = 1'b1;
                            key_code = KC_RIGHT;
                        end
                        CH_LEFT: begin
                            emit     = 1'b1;
                            key_code = KC_LEFT;
                        end
                        CH_TILDE: begin
                            if (count_inc == 4'd1) begin
                                emit = 1'b1;
                                case (state_cur.first_param)
                                    8'd1:    key_code = KC_HOME;
                                    8'd3:    key_code = KC_BKSP;
                                    8'd4:    key_code = KC_END;
                                    8'd5:    key_code = KC_UP;
                                    8'd6:    key_code = KC_DOWN;
                                    default: emit     = 1'b0;
                                endcase
                            end
                        end
                        default: begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/terminal_key_sequence_decoder_unit.sv @@
// Top level of the terminal key sequence decoder: input stage, state and result register.
// A byte waits in the input stage, and its key code then in the result register, which drives m_tvalid.
// Throughput: one byte per cycle while the output is not held back, as tksd_step updates the state combinationally.
// While a finished key code waits on the output, the input stage still takes one byte.
// Reset (aresetn low, synchronous) empties both stages and returns to normal mode
// with all parameter and code point state cleared.
module terminal_key_sequence_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [20:0] key_code, [23:21] zero
);
    import tksd_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    tksd_state_t state_reg;
    tksd_state_t state_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [20:0] m_code_reg;
    logic        step_emit;
    logic [20:0] step_code;
    logic        advance;

    // The held byte moves on once the result register is free or being emptied.
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    tksd_step u_step (
        .rx_byte   (in_byte_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .emit      (step_emit),
        .key_code  (step_code)
    );

    // Next values of the stage flags.
    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            m_valid_next = step_emit;
        end else begin
            m_valid_next = m_valid_reg && !m_tready;
        end
    end

    // Control and decoder state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '{mode: MODE_NORMAL, first_param: 8'd0, param_cnt: 4'd0,
                              accum: 21'd0, cont_left: 2'd0};
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && step_emit) begin
            m_code_reg <= step_code;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, m_code_reg};

`ifndef ASSERT_OFF
    // A held byte that cannot move on stays in place.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input stage lost or changed a held byte");

    // No code point is gathered without continuation bytes still due.
    a_accum_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.cont_left == 2'd0 |-> state_reg.accum == 21'd0)
        else $error("partial code point left with no continuation due");

    // Every key code lies within the Unicode range.
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_code_reg <= CODE_MAX)
        else $error("key code beyond the Unicode range");

    // Back-pressure on the input only when both stages are occupied and stalled.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && m_valid_reg && !m_tready)
        else $error("input refused without both stages full");
`endif

endmodule

@@ tb/sv/terminal_key_sequence_decoder_unit_tb.sv @@
// Self-checking testbench for the terminal key sequence decoder unit.
`timescale 1ns / 100ps

module terminal_key_sequence_decoder_unit_tb;
    import tksd_pkg::*;

    // Editing key parameters of the tilde-terminated sequences.
    localparam int VT_HOME   = 1;
    localparam int VT_DELETE = 3;
    localparam int VT_END    = 4;
    localparam int VT_PGUP   = 5;
    localparam int VT_PGDN   = 6;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 6;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [20:0] key_code, [23:21] zero

    terminal_key_sequence_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Decoder state as the testbench expects it to be.
    mode_t       dec_mode;
    logic [7:0]  csi_first;
    logic [3:0]  csi_count;
    logic [20:0] utf_accum;
    logic [1:0]  utf_pending;

    logic [20:0] pending_keys[$];
    logic [7:0]  token_bytes[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    int mismatch_count     = 0;
    int bytes_sent         = 0;
    int keys_checked       = 0;
    int input_stall_cycles = 0;
    int cycle_count        = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Plain text path: assembles UTF-8 and drops malformed partial code points.
    function automatic bit decode_text_byte(input logic [7:0] b, output logic [20:0] code);
        logic        bad;
        logic [20:0] acc;
        bad  = 1'b0;
        code = '0;
        if (utf_pending != 2'd0 && b[7:6] != 2'b10) begin
            utf_accum   = '0;
            utf_pending = 2'd0;
        end
        // Lead byte of a new code point; invalid leads are simply dropped.
        if (utf_pending == 2'd0) begin
            if (b < 8'h80) begin
                code = {13'd0, b};
                return 1'b1;
            end
            if (b >= 8'hC2 && b <= 8'hDF) begin
                utf_accum   = {16'd0, b[4:0]};
                utf_pending = 2'd1;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
                utf_accum   = {17'd0, b[3:0]};
                utf_pending = 2'd2;
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
                utf_accum   = {18'd0, b[2:0]};
                utf_pending = 2'd3;
            end
            return 1'b0;
        end
        // Overlong, surrogate and out-of-range forms show on the second byte.
        acc = utf_accum;
        if (utf_pending == 2'd3)
            bad = (acc == 21'd0 && b < 8'h90) || (acc == 21'd4 && b > 8'h8F);
        else if (utf_pending == 2'd2 && acc < 21'h10)
            bad = (acc == 21'd0 && b < 8'hA0) || (acc == 21'hD && b > 8'h9F);
        if (bad) begin
            utf_accum   = '0;
            utf_pending = 2'd0;
            return 1'b0;
        end
        utf_accum   = {acc[14:0], b[5:0]};
        utf_pending = utf_pending - 2'd1;
        if (utf_pending == 2'd0) begin
            code      = utf_accum;
            utf_accum = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Parameter collection and final byte of a CSI sequence.
    function automatic bit decode_csi_byte(input logic [7:0] b, output logic [20:0] code);
        int unsigned v;
        code = '0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            if (csi_count == 4'd0) begin
                v = int'(csi_first) * 10 + int'(b - CH_ZERO);
                csi_first = (v > 255) ? PARAM_MAX : 8'(v);
            end
            return 1'b0;
        end
        if (csi_count < COUNT_MAX)
            csi_count = csi_count + 4'd1;
        if (b == CH_SEMI)
            return 1'b0;
        dec_mode = MODE_NORMAL;
        case (b)
            CH_UP:    code = KC_UP;
            CH_DOWN:  code = KC_DOWN;
            CH_RIGHT: code = KC_RIGHT;
            CH_LEFT:  code = KC_LEFT;
            CH_TILDE: begin
                if (csi_count != 4'd1)
                    return 1'b0;
                case (int'(csi_first))
                    VT_HOME:   code = KC_HOME;
                    VT_DELETE: code = KC_BKSP;
                    VT_END:    code = KC_END;
                    VT_PGUP:   code = KC_UP;
                    VT_PGDN:   code = KC_DOWN;
                    default:   return 1'b0;
                endcase
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Expected key code, if any, for one received byte.
    function automatic bit decode_rx_byte(input logic [7:0] b, output logic [20:0] code);
        code = '0;
        case (dec_mode)
            MODE_NORMAL: begin
                if (b == KEY_ESC || b == KEY_DEL) begin
                    utf_accum   = '0;
                    utf_pending = 2'd0;
                end
                if (b == KEY_ESC) begin
                    dec_mode = MODE_ESC;
                    return 1'b0;
                end
                if (b == KEY_DEL) begin
                    code = KC_BKSP;
                    return 1'b1;
                end
                return decode_text_byte(b, code);
            end
            MODE_ESC: begin
                if (b == CH_LBRACKET) begin
                    csi_first = '0;
                    csi_count = '0;
                    dec_mode  = MODE_CSI;
                end else begin
                    dec_mode = MODE_NORMAL;
                end
                return 1'b0;
            end
            MODE_CSI: return decode_csi_byte(b, code);
            default: begin
                dec_mode = MODE_NORMAL;
                return 1'b0;
            end
        endcase
    endfunction

    // Offers one byte, waits for its transfer and records the expected key.
    task automatic send_rx_byte(input logic [7:0] b);
        logic [20:0] code;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        if (decode_rx_byte(b, code))
            pending_keys.push_back(code);
        bytes_sent++;
    endtask

    task automatic send_token;
        foreach (token_bytes[i])
            send_rx_byte(token_bytes[i]);
    endtask

    // Appends the UTF-8 encoding of a random code point of the given length.
    function automatic void push_utf8_char(input int len);
        logic [20:0] cp;
        int          pick;
        pick = $urandom_range(9);
        case (len)
            1: cp = 21'($urandom_range(0, 8'h7F));
            2: cp = 21'($urandom_range(12'h080, 12'h7FF));
            3: begin
                do cp = 21'($urandom_range(16'h0800, 16'hFFFF));
                while (cp >= 21'hD800 && cp <= 21'hDFFF);
            end
            default: cp = 21'($urandom_range(21'h10000, CODE_MAX));
        endcase
        // Now and then take the ends of each length's range.
        if (pick == 0)
            cp = (len == 1) ? 21'h0 : (len == 2) ? 21'h80 : (len == 3) ? 21'h800 : 21'h10000;
        else if (pick == 1)
            cp = (len == 1) ? 21'h7F : (len == 2) ? 21'h7FF : (len == 3) ? 21'hFFFF : CODE_MAX;
        case (len)
            1: token_bytes.push_back(cp[7:0]);
            2: begin
                token_bytes.push_back({3'b110, cp[10:6]});
                token_bytes.push_back({2'b10, cp[5:0]});
            end
            3: begin
                token_bytes.push_back({4'b1110, cp[15:12]});
                token_bytes.push_back({2'b10, cp[11:6]});
                token_bytes.push_back({2'b10, cp[5:0]});
            end
            default: begin
                token_bytes.push_back({5'b11110, cp[20:18]});
                token_bytes.push_back({2'b10, cp[17:12]});
                token_bytes.push_back({2'b10, cp[11:6]});
                token_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // Builds one random piece of terminal traffic, mostly well-formed.
    function automatic void build_random_token;
        int    kind;
        int    n_params;
        int    len;
        int    value;
        string digits;
        token_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 30) begin
            // CSI sequence with random parameters and final byte.
            n_params = ($urandom_range(99) < 8) ? $urandom_range(15, 18) : $urandom_range(0, 3);
            token_bytes.push_back(KEY_ESC);
            token_bytes.push_back(CH_LBRACKET);
            for (int i = 0; i < n_params; i++) begin
                if (i != 0)
                    token_bytes.push_back(CH_SEMI);
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: value = $urandom_range(VT_HOME, VT_PGDN);
                    5, 6:          value = $urandom_range(0, 9);
                    7:             value = $urandom_range(256, 99999);
                    8:             value = $urandom_range(0, 255);
                    default:       value = -1;
                endcase
                if (value >= 0) begin
                    digits = $sformatf("%0d", value);
                    for (int k = 0; k < digits.len(); k++)
                        token_bytes.push_back(8'(digits[k]));
                end
            end
            case ($urandom_range(9))
                0, 1, 2, 3: token_bytes.push_back(CH_TILDE);
                4, 5, 6, 7: token_bytes.push_back(CH_UP + 8'($urandom_range(3)));
                8:          token_bytes.push_back(8'($urandom_range(8'h40, 8'h7E)));
                default:    token_bytes.push_back(8'($urandom_range(255)));
            endcase
        end else if (kind < 38) begin
            // ESC followed by anything.
            token_bytes.push_back(KEY_ESC);
            token_bytes.push_back(8'($urandom_range(255)));
        end else if (kind < 63) begin
            push_utf8_char($urandom_range(1, 4));
        end else if (kind < 75) begin
            // Malformed UTF-8.
            case ($urandom_range(2))
                0: begin
                    len = $urandom_range(2, 4);
                    push_utf8_char(len);
                    repeat ($urandom_range(1, len - 1)) void'(token_bytes.pop_back());
                    token_bytes.push_back($urandom_range(1) ? 8'($urandom_range(8'h7F)) :
                                          8'($urandom_range(8'hC0, 8'hFF)));
                end
                1: begin
                    case ($urandom_range(3))
                        0: begin
                            token_bytes.push_back(8'hE0);
                            token_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
                        end
                        1: begin
                            token_bytes.push_back(8'hED);
                            token_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                        end
                        2: begin
                            token_bytes.push_back(8'hF0);
                            token_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
                        end
                        default: begin
                            token_bytes.push_back(8'hF4);
                            token_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
                        end
                    endcase
                    token_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                default: token_bytes.push_back($urandom_range(1) ?
                                               8'($urandom_range(8'h80, 8'hC1)) :
                                               8'($urandom_range(8'hF5, 8'hFF)));
            endcase
        end else if (kind < 90) begin
            token_bytes.push_back($urandom_range(9) == 0 ? KEY_DEL :
                                  8'($urandom_range(8'h20, 8'h7E)));
        end else begin
            token_bytes.push_back(8'($urandom_range(255)));
        end
    endfunction

    // Receiver: random stalls, plus one long hold-off when asked for.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            m_tready  <= 1'b0;
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Each result transfer is compared with the oldest expected key code.
    always @(posedge aclk) begin
        logic [20:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_keys.size() == 0) begin
                report_mismatch($sformatf("key code %h with none expected", m_tdata[20:0]));
            end else begin
                want = pending_keys.pop_front();
                keys_checked++;
                if (m_tdata[20:0] !== want)
                    report_mismatch($sformatf("key code %h, expected %h", m_tdata[20:0], want));
            end
        end
        if (aresetn && s_tvalid && !s_tready)
            input_stall_cycles++;
    end

    // Guards against a hang.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d keys outstanding",
                     cycle_count, pending_keys.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic apply_reset;
        dec_mode    = MODE_NORMAL;
        csi_first   = '0;
        csi_count   = '0;
        utf_accum   = '0;
        utf_pending = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    endtask

    // Extremes of the byte, an arrow and a tilde key, and the main error paths.
    task automatic test_directed_edges;
        logic [7:0] seq[$];
        send_idle_pct = 0;
        recv_idle_pct = 0;
        seq = '{8'h61, 8'h00, KEY_DEL, 8'hFF,
                KEY_ESC, CH_LBRACKET, CH_UP,
                KEY_ESC, CH_LBRACKET, 8'h33, CH_TILDE,
                KEY_ESC, 8'h78,
                8'hC2, 8'h80,
                8'hF4, 8'h8F, 8'hBF, 8'hBF,
                8'hED, 8'hA0,
                8'hC3, 8'h41,
                8'hE2, KEY_DEL};
        foreach (seq[i])
            send_rx_byte(seq[i]);
    endtask

    task automatic test_random_traffic(input int byte_target, input int send_pct,
                                       input int recv_pct);
        int start_count;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_count   = bytes_sent;
        while (bytes_sent - start_count < byte_target) begin
            build_random_token();
            send_token();
        end
    endtask

    // Long receiver hold-off while bytes keep coming, so the input stalls.
    task automatic test_backpressure_fill;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req <= hold_req + 1;
        repeat (40) send_rx_byte(8'($urandom_range(8'h20, 8'h7E)));
    endtask

    initial begin
        apply_reset();
        test_directed_edges();
        test_random_traffic(200, 18, 79);
        test_random_traffic(200, 79, 18);
        test_backpressure_fill();
        test_random_traffic(200, 0, 0);
        s_tvalid <= 1'b0;
        while (pending_keys.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d bytes of text, CSI and malformed UTF-8 traffic; %0d keys checked.",
                 bytes_sent, keys_checked);
        $display("Input held back for %0d cycles by output back-pressure; %0d mismatches.",
                 input_stall_cycles, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
rtl/tksd_pkg.sv
rtl/tksd_step.sv
rtl/terminal_key_sequence_decoder_unit.sv
tb/sv/terminal_key_sequence_decoder_unit_tb.sv
